// ===== hw/rtl/ctwa_pkg.sv =====
`default_nettype none
package ctwa_pkg;

    localparam int CAPACITY_DEF = 20;
    localparam int ADDR_W = 48;
    localparam int TIME_W = 32;
    localparam int CNT_W = 5;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd3600000;

    localparam logic [1:0] ACT_LEARN  = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_SWEEP  = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] station_addr;
        logic [TIME_W-1:0] now_ms;
    } t_cmd;

    typedef struct packed {
        logic             was_present;
        logic             was_added;
        logic             was_dropped;
        logic [CNT_W-1:0] removed_count;
        logic [CNT_W-1:0] entry_count;
    } t_result;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LEARN,
        CELL_MARK,
        CELL_SHIFT
    } t_cell_op;

    // broadcast to every cell of the row
    typedef struct packed {
        t_cell_op          op;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] timeout;
        logic              append_ok;
    } t_cell_ctl;

    typedef struct packed {
        logic              valid;
        logic              kill;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] seen;
    } t_entry;

endpackage
`default_nettype wire

// ===== hw/rtl/client_table_with_aging_top.sv =====
`default_nettype none
// learn and lookup: EXEC registers the result; a new start waits until busy drops
// sweep: EXEC marks the stale entries; SWEEP strobes the result once none is left;
//   cells drop one stale entry per cycle, shifting the suffix behind it one cell down
// results are strobed on o_done for one cycle; the receiver cannot stall
// synchronous active-low reset empties the table and loads the timeout with 3600000
module client_table_with_aging_top #(
    parameter int CAPACITY = ctwa_pkg::CAPACITY_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire ctwa_pkg::t_cmd              i_cmd,
    input  wire logic                        i_cfg_we,
    input  wire logic [ctwa_pkg::TIME_W-1:0] i_cfg_data,
    output logic                             o_done,
    output ctwa_pkg::t_result                o_result
);
    import ctwa_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP
    } t_state;

    t_state            r_state;
    t_cmd              r_cmd;
    logic [TIME_W-1:0] r_timeout;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_removed;
    logic              r_done;
    t_result           r_result;
    t_result           n_result;

    t_cell_ctl         ctl;
    t_entry            ent [CAPACITY+1];
    logic [CAPACITY:0] sh;
    logic [CAPACITY-1:0] hits;
    logic              any_hit;
    logic              full;
    logic              any_kill;
    logic              accept;

    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign any_hit  = |hits;
    assign full     = ent[CAPACITY-1].valid;
    assign any_kill = sh[CAPACITY];
    assign o_done   = r_done;
    assign o_result = r_result;

    assign ent[CAPACITY] = '{valid: 1'b0, kill: 1'b0, addr: '0, seen: '0};
    assign sh[0] = 1'b0;

    always_comb begin
        ctl.addr      = r_cmd.station_addr;
        ctl.now       = r_cmd.now_ms;
        ctl.timeout   = r_timeout;
        ctl.append_ok = !any_hit && !full;
        ctl.op        = CELL_HOLD;
        unique case (r_state)
            S_EXEC: begin
                if (r_cmd.action == ACT_LEARN) ctl.op = CELL_LEARN;
                else if (r_cmd.action == ACT_SWEEP) ctl.op = CELL_MARK;
            end
            S_SWEEP: begin
                if (any_kill) ctl.op = CELL_SHIFT;
            end
            default: ;
        endcase
    end

    // result of a learn, lookup or unused action
    always_comb begin
        n_result = '0;
        n_result.entry_count = CNT_W'(r_count);
        if (r_cmd.action == ACT_LOOKUP) begin
            n_result.was_present = any_hit;
        end else if (r_cmd.action == ACT_LEARN) begin
            n_result.was_present = any_hit;
            n_result.was_dropped = !any_hit && full;
            if (!any_hit && !full) begin
                n_result.was_added   = 1'b1;
                n_result.entry_count = CNT_W'(r_count + 1'b1);
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic prev_valid;
        if (g == 0) begin : g_head
            assign prev_valid = 1'b1;
        end else begin : g_body
            assign prev_valid = ent[g-1].valid;
        end
        ctwa_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_next       (ent[g+1]),
            .i_prev_valid (prev_valid),
            .i_shift      (sh[g]),
            .o_entry      (ent[g]),
            .o_shift      (sh[g+1]),
            .o_hit        (hits[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_cmd <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_removed <= '0;
            r_done    <= 1'b0;
            r_result  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_done <= 1'b0;
                    if (accept) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (r_cmd.action == ACT_SWEEP) begin
                        r_done    <= 1'b0;
                        r_removed <= '0;
                        r_state   <= S_SWEEP;
                    end else begin
                        r_done   <= 1'b1;
                        r_result <= n_result;
                        r_state  <= S_IDLE;
                        if (r_cmd.action == ACT_LEARN && !any_hit && !full) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                S_SWEEP: begin
                    if (any_kill) begin
                        r_done    <= 1'b0;
                        r_removed <= r_removed + 1'b1;
                        r_count   <= r_count - 1'b1;
                    end else begin
                        r_result <= '{was_present: 1'b0, was_added: 1'b0, was_dropped: 1'b0,
                                      removed_count: CNT_W'(r_removed),
                                      entry_count: CNT_W'(r_count)};
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ctwa_cell.sv =====
`default_nettype none
module ctwa_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ctwa_pkg::t_cell_ctl i_ctl,
    input  wire ctwa_pkg::t_entry   i_next,
    input  wire logic               i_prev_valid,
    input  wire logic               i_shift,
    output ctwa_pkg::t_entry        o_entry,
    output logic                    o_shift,
    output logic                    o_hit
);
    import ctwa_pkg::*;

    logic              r_valid;
    logic              r_kill;
    logic [ADDR_W-1:0] r_addr;
    logic [TIME_W-1:0] r_seen;
    logic [TIME_W-1:0] age;
    logic              take_next;
    logic              append_here;

    assign o_hit       = r_valid && (r_addr == i_ctl.addr);
    assign age         = i_ctl.now - r_seen;
    assign o_shift     = i_shift | r_kill;
    // first free cell of the packed prefix
    assign append_here = !r_valid && i_prev_valid && i_ctl.append_ok;
    assign take_next   = (i_ctl.op == CELL_SHIFT) && o_shift;

    assign o_entry.valid = r_valid;
    assign o_entry.kill  = r_kill;
    assign o_entry.addr  = r_addr;
    assign o_entry.seen  = r_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_kill  <= 1'b0;
        end else begin
            unique case (i_ctl.op)
                CELL_LEARN: begin
                    if (append_here) r_valid <= 1'b1;
                end
                CELL_MARK: begin
                    r_kill <= r_valid && (age > i_ctl.timeout);
                end
                CELL_SHIFT: begin
                    if (take_next) begin
                        r_valid <= i_next.valid;
                        r_kill  <= i_next.kill;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            CELL_LEARN: begin
                if (o_hit) begin
                    r_seen <= i_ctl.now;
                end else if (append_here) begin
                    r_addr <= i_ctl.addr;
                    r_seen <= i_ctl.now;
                end
            end
            CELL_SHIFT: begin
                if (take_next) begin
                    r_addr <= i_next.addr;
                    r_seen <= i_next.seen;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire
